FILE: hdl/uifr_pkg.sv
// Shared types and constants for the idle-line UART frame receiver.
// No dependencies; imported by the top level.
package uifr_pkg;

  typedef enum logic [2:0] {
    OP_BYTE    = 3'd0,
    OP_IDLE    = 3'd1,
    OP_ERROR   = 3'd2,
    OP_RECOVER = 3'd3,
    OP_TAKE    = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FE_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_PE_LIMIT    = 3'd1;
  localparam logic [2:0] CFG_ERR_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_FAULT_CLEAR = 3'd3;
  localparam logic [2:0] CFG_MAX_RETRIES = 3'd4;

  // statistics counter selects
  localparam int          CNT_NUM       = 6;
  localparam logic [2:0]  CNT_ERRORS    = 3'd0;
  localparam logic [2:0]  CNT_OVERFLOWS = 3'd1;
  localparam logic [2:0]  CNT_ORE       = 3'd2;
  localparam logic [2:0]  CNT_FE        = 3'd3;
  localparam logic [2:0]  CNT_NE        = 3'd4;
  localparam logic [2:0]  CNT_PE        = 3'd5;
  localparam logic [7:0]  SEL_RETRIES   = 8'd6;

  // error word bit positions
  localparam int ERR_PARITY  = 0;
  localparam int ERR_NOISE   = 1;
  localparam int ERR_FRAMING = 2;
  localparam int ERR_OVERRUN = 3;

  // restart outcome codes
  localparam logic [1:0] RESTART_OK   = 2'd0;
  localparam logic [1:0] RESTART_BUSY = 2'd1;

  localparam logic [31:0] MIN_ATTEMPT_GAP_MS = 32'd5;
  localparam logic [7:0]  GOOD_RUN_MAX       = 8'd255;

  // status captured at acceptance, waiting for the byte store read
  typedef struct packed {
    logic        frame_waiting;
    logic [8:0]  taken_length;
    logic        rd_byte;
    logic [31:0] counter_value;
    logic        recovery_pending;
    logic        hardware_fault;
    logic        recovery_tried;
  } stage_t;

endpackage

FILE: hdl/uifr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uifr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/uart_idle_frame_receiver_top.sv
// Idle-line UART frame receiver: double byte buffer, error statistics, recovery.
// Each result is registered in stage s1_r, then in the output register; one item per cycle
// unless out_tready stalls it. The byte store RAM (uifr_ram) read is registered with s1_r.
// Reset (rst_n low, synchronous) clears control state, counters and config to
// defaults; the byte store is not cleared and holds garbage until written.
// Depends on uifr_pkg and uifr_ram.
module uart_idle_frame_receiver_top
  import uifr_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rx_byte[7:0], error_bits[12:8], max_length[21:13], read_index[29:22],
  // restart_outcome[31:30], now_ms[63:32]
  input  logic [63:0] in_tdata,
  // opcode[2:0], echo_window[3], read_counter[4]
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_waiting[0], taken_length[9:1], read_data[17:10], counter_value[49:18],
  // recovery_pending[50], hardware_fault[51], recovery_tried[52], zero[55:53]
  output logic [55:0] out_tdata
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int IW = $clog2(BUFFER_BYTES);
  localparam int AW = IW + 1;
  localparam int WW = (CW > 9) ? CW : 9;
  localparam logic [WW-1:0] BB_W   = WW'(BUFFER_BYTES);
  localparam logic [CW-1:0] BB_C   = CW'(BUFFER_BYTES);
  localparam logic [CW-1:0] LAST_C = CW'(BUFFER_BYTES - 1);

  // input fields
  op_t         in_op;
  logic [7:0]  in_rx_byte;
  logic        in_echo;
  logic [4:0]  in_err;
  logic [8:0]  in_max_len;
  logic [7:0]  in_idx;
  logic        in_rdcnt;
  logic [1:0]  in_restart;
  logic [31:0] in_now;

  assign in_op      = op_t'(in_tuser[2:0]);
  assign in_echo    = in_tuser[3];
  assign in_rdcnt   = in_tuser[4];
  assign in_rx_byte = in_tdata[7:0];
  assign in_err     = in_tdata[12:8];
  assign in_max_len = in_tdata[21:13];
  assign in_idx     = in_tdata[29:22];
  assign in_restart = in_tdata[31:30];
  assign in_now     = in_tdata[63:32];

  // configuration
  logic [7:0] fe_lim_r, pe_lim_r, err_lim_r, fclr_r, max_retry_r;

  // control state
  logic          active_r, active_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] rlen_r, rlen_nxt;
  logic          ready_r, ready_nxt;
  logic          rreq_r, rreq_nxt;
  logic          fault_r, fault_nxt;
  logic [7:0]    gfr_r, gfr_nxt;
  logic [31:0]   retry_r, retry_nxt;
  logic [31:0]   any_str_r, any_str_nxt;
  logic [31:0]   fe_str_r, fe_str_nxt;
  logic [31:0]   pe_str_r, pe_str_nxt;
  logic [31:0]   stat_r [CNT_NUM];
  logic [31:0]   stat_nxt [CNT_NUM];
  logic [31:0]   last_ms_r, last_ms_nxt;

  // pipeline
  logic   v1_r;
  stage_t s1_r, s1_nxt;
  logic   out_v_r;
  logic [55:0] out_data_r;
  logic   in_acc, adv1;

  // byte store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_q;

  assign adv1       = !out_v_r || out_tready;
  assign in_tready  = !v1_r || adv1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // byte index into one buffer half
  function automatic logic [IW-1:0] in_idx_ext(input logic [7:0] idx);
    logic [WW-1:0] wide;
    wide = WW'(idx);
    return wide[IW-1:0];
  endfunction

  always_comb begin
    logic          seen, urgent;
    logic [31:0]   fe_inc, pe_inc, any_inc, retry_inc;
    logic [7:0]    gfr_inc;
    logic [WW-1:0] snap, lim_w;
    logic [8:0]    taken;
    logic          rd_byte;
    logic [31:0]   cnt_val;
    logic          tried;

    seen      = 1'b0;
    urgent    = 1'b0;
    fe_inc    = fe_str_r + 32'd1;
    pe_inc    = pe_str_r + 32'd1;
    any_inc   = any_str_r + 32'd1;
    retry_inc = retry_r + 32'd1;
    gfr_inc   = (gfr_r == GOOD_RUN_MAX) ? gfr_r : gfr_r + 8'd1;
    snap      = '0;
    lim_w     = WW'(in_max_len);
    taken     = '0;
    rd_byte   = 1'b0;
    cnt_val   = '0;
    tried     = 1'b0;

    active_nxt  = active_r;
    fill_nxt    = fill_r;
    rlen_nxt    = rlen_r;
    ready_nxt   = ready_r;
    rreq_nxt    = rreq_r;
    fault_nxt   = fault_r;
    gfr_nxt     = gfr_r;
    retry_nxt   = retry_r;
    any_str_nxt = any_str_r;
    fe_str_nxt  = fe_str_r;
    pe_str_nxt  = pe_str_r;
    last_ms_nxt = last_ms_r;
    stat_nxt    = stat_r;

    ram_we    = 1'b0;
    ram_waddr = {active_r, fill_r[IW-1:0]};
    ram_re    = 1'b0;
    ram_raddr = {~active_r, in_idx_ext(in_idx)};

    if (in_acc) begin
      unique case (in_op)
        OP_BYTE: begin
          if (!in_echo) begin
            if (fill_r < BB_C) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + CW'(1);
              if (fill_r == LAST_C) begin
                stat_nxt[CNT_OVERFLOWS] = stat_r[CNT_OVERFLOWS] + 32'd1;
                rreq_nxt = 1'b1;
              end
            end else begin
              stat_nxt[CNT_OVERFLOWS] = stat_r[CNT_OVERFLOWS] + 32'd1;
              rreq_nxt = 1'b1;
            end
          end
        end
        OP_IDLE: begin
          if (fill_r != '0) begin
            if (ready_r) begin
              // previous frame not taken: keep the active buffer as is
              stat_nxt[CNT_OVERFLOWS] = stat_r[CNT_OVERFLOWS] + 32'd1;
              rreq_nxt = 1'b1;
            end else begin
              active_nxt = ~active_r;
              rlen_nxt   = fill_r;
              fill_nxt   = '0;
              ready_nxt  = 1'b1;
              if (fault_r) begin
                if (gfr_inc >= fclr_r) begin
                  fault_nxt = 1'b0;
                  retry_nxt = '0;
                  gfr_nxt   = '0;
                end else begin
                  gfr_nxt = gfr_inc;
                end
              end else begin
                gfr_nxt = '0;
              end
              if (in_restart != RESTART_OK) begin
                rreq_nxt = 1'b1;
              end
            end
          end
        end
        OP_ERROR: begin
          if (in_err == '0) begin
            any_str_nxt = '0;
            fe_str_nxt  = '0;
            pe_str_nxt  = '0;
          end else begin
            if (in_err[ERR_OVERRUN]) begin
              stat_nxt[CNT_ORE] = stat_r[CNT_ORE] + 32'd1;
              seen   = 1'b1;
              urgent = 1'b1;
            end
            if (in_err[ERR_FRAMING] || in_err[ERR_NOISE]) begin
              if (in_err[ERR_FRAMING]) begin
                stat_nxt[CNT_FE] = stat_r[CNT_FE] + 32'd1;
              end
              if (in_err[ERR_NOISE]) begin
                stat_nxt[CNT_NE] = stat_r[CNT_NE] + 32'd1;
              end
              fe_str_nxt = fe_inc;
              seen       = 1'b1;
              if (fe_inc >= {24'd0, fe_lim_r}) begin
                urgent = 1'b1;
              end
            end
            if (in_err[ERR_PARITY]) begin
              stat_nxt[CNT_PE] = stat_r[CNT_PE] + 32'd1;
              pe_str_nxt = pe_inc;
              seen       = 1'b1;
              if (pe_inc >= {24'd0, pe_lim_r}) begin
                urgent = 1'b1;
              end
            end
            if (!seen) begin
              any_str_nxt = '0;
            end else begin
              stat_nxt[CNT_ERRORS] = stat_r[CNT_ERRORS] + 32'd1;
              any_str_nxt = any_inc;
              if (urgent || (any_inc >= {24'd0, err_lim_r})) begin
                rreq_nxt = 1'b1;
              end
            end
          end
        end
        OP_RECOVER: begin
          if (rreq_r && !ready_r && !fault_r &&
              ((in_now - last_ms_r) >= MIN_ATTEMPT_GAP_MS)) begin
            tried       = 1'b1;
            last_ms_nxt = in_now;
            rreq_nxt    = 1'b0;
            fill_nxt    = '0;
            rlen_nxt    = '0;
            ready_nxt   = 1'b0;
            if (in_restart != RESTART_OK) begin
              retry_nxt = retry_inc;
              if (in_restart != RESTART_BUSY) begin
                stat_nxt[CNT_ERRORS] = stat_r[CNT_ERRORS] + 32'd1;
              end
              if (retry_inc >= {24'd0, max_retry_r}) begin
                fault_nxt = 1'b1;
                rreq_nxt  = 1'b0;
              end else begin
                rreq_nxt = 1'b1;
              end
            end else begin
              retry_nxt = '0;
            end
          end
        end
        OP_TAKE: begin
          if ((in_max_len != '0) && (lim_w <= BB_W)) begin
            if (ready_r) begin
              snap      = WW'(rlen_r);
              rlen_nxt  = '0;
              ready_nxt = 1'b0;
            end
            taken = (snap < lim_w) ? snap[8:0] : in_max_len;
          end
        end
        OP_READ: begin
          if (in_rdcnt) begin
            if (in_idx < SEL_RETRIES) begin
              cnt_val = stat_r[in_idx[2:0]];
            end else if (in_idx == SEL_RETRIES) begin
              cnt_val = retry_r;
            end
          end else if (WW'(in_idx) < BB_W) begin
            rd_byte = 1'b1;
            ram_re  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    s1_nxt.frame_waiting    = ready_nxt;
    s1_nxt.taken_length     = taken;
    s1_nxt.rd_byte          = rd_byte;
    s1_nxt.counter_value    = cnt_val;
    s1_nxt.recovery_pending = rreq_nxt;
    s1_nxt.hardware_fault   = fault_nxt;
    s1_nxt.recovery_tried   = tried;
  end

  uifr_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_lim_r    <= 8'd3;
      pe_lim_r    <= 8'd5;
      err_lim_r   <= 8'd8;
      fclr_r      <= 8'd5;
      max_retry_r <= 8'd3;
      active_r    <= 1'b0;
      fill_r      <= '0;
      rlen_r      <= '0;
      ready_r     <= 1'b0;
      rreq_r      <= 1'b0;
      fault_r     <= 1'b0;
      gfr_r       <= '0;
      retry_r     <= '0;
      any_str_r   <= '0;
      fe_str_r    <= '0;
      pe_str_r    <= '0;
      last_ms_r   <= '0;
      for (int i = 0; i < CNT_NUM; i++) begin
        stat_r[i] <= '0;
      end
      v1_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FE_LIMIT:    fe_lim_r    <= cfg_wdata;
          CFG_PE_LIMIT:    pe_lim_r    <= cfg_wdata;
          CFG_ERR_LIMIT:   err_lim_r   <= cfg_wdata;
          CFG_FAULT_CLEAR: fclr_r      <= cfg_wdata;
          CFG_MAX_RETRIES: max_retry_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      active_r  <= active_nxt;
      fill_r    <= fill_nxt;
      rlen_r    <= rlen_nxt;
      ready_r   <= ready_nxt;
      rreq_r    <= rreq_nxt;
      fault_r   <= fault_nxt;
      gfr_r     <= gfr_nxt;
      retry_r   <= retry_nxt;
      any_str_r <= any_str_nxt;
      fe_str_r  <= fe_str_nxt;
      pe_str_r  <= pe_str_nxt;
      last_ms_r <= last_ms_nxt;
      stat_r    <= stat_nxt;
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        out_v_r <= v1_r;
      end
    end
  end

  // payload: hold the stage while the output stalls; RAM data holds with it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (adv1 && v1_r) begin
      out_data_r <= {3'b000,
                     s1_r.recovery_tried,
                     s1_r.hardware_fault,
                     s1_r.recovery_pending,
                     s1_r.counter_value,
                     (s1_r.rd_byte ? ram_q : 8'd0),
                     s1_r.taken_length,
                     s1_r.frame_waiting};
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BB_C)
    else $error("fill count beyond buffer size");

  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv1) |=> $stable(ram_q))
    else $error("store read data changed under a stalled stage");

  a_tried_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s1_r.recovery_tried) |-> !s1_r.frame_waiting)
    else $error("recovery attempt left a frame waiting");

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_TAKE) && (s1_nxt.taken_length != '0)) |=> !ready_r)
    else $error("frame still waiting after a take");
`endif

endmodule

FILE: test/uart_idle_frame_receiver_top_test.sv
// Self-checking testbench for uart_idle_frame_receiver_top: directed cases, full-buffer
// frames and randomized traffic under several limit settings, checked by a predictor.
// Depends on uifr_pkg and the receiver RTL.
module uart_idle_frame_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uifr_pkg::*;

  localparam int         BUF_BYTES        = 256;
  localparam logic [2:0] OP_RSVD6         = 3'd6;
  localparam logic [2:0] OP_RSVD7         = 3'd7;
  localparam logic [1:0] RESTART_FAIL     = 2'd2;
  localparam logic [1:0] RESTART_FAIL_ALT = 2'd3;
  localparam int         ERR_OTHER        = 4;
  localparam logic [7:0] SEL_NONE         = 8'd7;
  localparam logic [8:0] MAX_TAKE         = 9'd256;

  typedef struct {
    logic [2:0]  opcode;
    logic [7:0]  rx_byte;
    logic        echo;
    logic [4:0]  error_bits;
    logic [8:0]  max_length;
    logic [7:0]  read_index;
    logic        read_counter;
    logic [1:0]  restart;
    logic [31:0] now_ms;
  } rx_item_t;

  typedef struct {
    logic        frame_waiting;
    logic [8:0]  taken_length;
    logic [7:0]  read_data;
    logic [31:0] counter_value;
    logic        recovery_pending;
    logic        hardware_fault;
    logic        recovery_tried;
  } rx_status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  // rx_byte, error_bits, max_length, read_index, restart_outcome, now_ms
  logic [63:0] in_tdata;
  // opcode, echo_window, read_counter
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // frame_waiting, taken_length, read_data, counter_value, recovery_pending,
  // hardware_fault, recovery_tried, zero padding
  logic [55:0] out_tdata;

  // predictor copy of the limits
  logic [7:0]  lim_fe       = 8'd3;
  logic [7:0]  lim_pe       = 8'd5;
  logic [7:0]  lim_err      = 8'd8;
  logic [7:0]  clear_frames = 8'd5;
  logic [7:0]  max_retries  = 8'd3;

  // predictor copy of the receiver state
  logic [7:0]  frame_store [0:2*BUF_BYTES-1];
  logic [8:0]  written_span [2] = '{default: '0};
  logic        active_half  = 1'b0;
  logic [8:0]  fill_count   = '0;
  logic [8:0]  ready_len    = '0;
  logic        frame_held   = 1'b0;
  logic        recover_req  = 1'b0;
  logic        fault        = 1'b0;
  logic [7:0]  good_run     = '0;
  logic [31:0] retries      = '0;
  logic [31:0] err_streak   = '0;
  logic [31:0] fe_streak    = '0;
  logic [31:0] pe_streak    = '0;
  logic [31:0] stat_count [CNT_NUM] = '{default: '0};
  logic [31:0] last_try_ms  = '0;

  rx_status_t  expected_status [$];
  int          fail_count    = 0;
  int          items_sent    = 0;
  logic [31:0] clock_ms      = '0;
  bit          in_gaps_on    = 1'b1;
  bit          out_stalls_on = 1'b1;

  uart_idle_frame_receiver_top #(
    .BUFFER_BYTES(BUF_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("uart_idle_frame_receiver_top_test: done, errors");
    $finish;
  end

  function automatic void note_overflow();
    stat_count[CNT_OVERFLOWS]++;
    recover_req = 1'b1;
  endfunction

  // Advance the predicted receiver by one item and return the status it reports.
  function automatic rx_status_t apply_rx_item(rx_item_t it);
    rx_status_t st;
    logic       seen;
    logic       urgent;
    logic [8:0] snap;
    st = '{default: '0};
    case (it.opcode)
      OP_BYTE: if (!it.echo) begin
        if (fill_count < BUF_BYTES) begin
          frame_store[{active_half, fill_count[7:0]}] = it.rx_byte;
          fill_count++;
          if (fill_count > written_span[active_half]) written_span[active_half] = fill_count;
          if (fill_count >= BUF_BYTES) note_overflow();
        end else begin
          note_overflow();
        end
      end
      OP_IDLE: if (fill_count != 0) begin
        if (frame_held) begin
          note_overflow();
        end else begin
          active_half = ~active_half;
          ready_len   = fill_count;
          fill_count  = '0;
          frame_held  = 1'b1;
          if (fault) begin
            if (good_run < GOOD_RUN_MAX) good_run++;
            if (good_run >= clear_frames) begin
              fault    = 1'b0;
              retries  = '0;
              good_run = '0;
            end
          end else begin
            good_run = '0;
          end
          if (it.restart != RESTART_OK) recover_req = 1'b1;
        end
      end
      OP_ERROR: if (it.error_bits == '0) begin
        err_streak = '0;
        fe_streak  = '0;
        pe_streak  = '0;
      end else begin
        seen   = 1'b0;
        urgent = 1'b0;
        if (it.error_bits[ERR_OVERRUN]) begin
          stat_count[CNT_ORE]++;
          seen   = 1'b1;
          urgent = 1'b1;
        end
        if (it.error_bits[ERR_FRAMING] || it.error_bits[ERR_NOISE]) begin
          if (it.error_bits[ERR_FRAMING]) stat_count[CNT_FE]++;
          if (it.error_bits[ERR_NOISE]) stat_count[CNT_NE]++;
          fe_streak++;
          seen = 1'b1;
          if (fe_streak >= lim_fe) urgent = 1'b1;
        end
        if (it.error_bits[ERR_PARITY]) begin
          stat_count[CNT_PE]++;
          pe_streak++;
          seen = 1'b1;
          if (pe_streak >= lim_pe) urgent = 1'b1;
        end
        if (!seen) begin
          err_streak = '0;
        end else begin
          stat_count[CNT_ERRORS]++;
          err_streak++;
          if (urgent || err_streak >= lim_err) recover_req = 1'b1;
        end
      end
      OP_RECOVER: if (recover_req && !frame_held && !fault &&
                      (it.now_ms - last_try_ms) >= MIN_ATTEMPT_GAP_MS) begin
        st.recovery_tried = 1'b1;
        last_try_ms = it.now_ms;
        recover_req = 1'b0;
        fill_count  = '0;
        ready_len   = '0;
        frame_held  = 1'b0;
        if (it.restart != RESTART_OK) begin
          retries++;
          if (it.restart != RESTART_BUSY) stat_count[CNT_ERRORS]++;
          if (retries >= max_retries) fault = 1'b1;
          else recover_req = 1'b1;
        end else begin
          retries = '0;
        end
      end
      OP_TAKE: if (it.max_length != 0 && it.max_length <= BUF_BYTES) begin
        snap = '0;
        if (frame_held) begin
          snap       = ready_len;
          ready_len  = '0;
          frame_held = 1'b0;
        end
        st.taken_length = (snap < it.max_length) ? snap : it.max_length;
      end
      OP_READ: begin
        if (it.read_counter) begin
          if (it.read_index < CNT_NUM) st.counter_value = stat_count[it.read_index[2:0]];
          else if (it.read_index == SEL_RETRIES) st.counter_value = retries;
        end else if (it.read_index < BUF_BYTES) begin
          st.read_data = frame_store[{~active_half, it.read_index}];
        end
      end
      default: ;
    endcase
    st.frame_waiting    = frame_held;
    st.recovery_pending = recover_req;
    st.hardware_fault   = fault;
    return st;
  endfunction

  function automatic rx_item_t random_item(logic [2:0] op);
    rx_item_t it;
    it.opcode       = op;
    it.rx_byte      = 8'($urandom);
    it.echo         = 1'($urandom);
    it.error_bits   = 5'($urandom);
    it.max_length   = 9'($urandom);
    it.read_index   = 8'($urandom);
    it.read_counter = 1'($urandom);
    it.restart      = 2'($urandom);
    it.now_ms       = $urandom;
    return it;
  endfunction

  function automatic logic [1:0] pick_outcome();
    logic [1:0] outcome;
    outcome = RESTART_OK;
    if ($urandom_range(0, 3) == 0) outcome = 2'($urandom_range(1, 3));
    return outcome;
  endfunction

  function automatic logic [8:0] pick_take_limit();
    logic [8:0] limit;
    case ($urandom_range(0, 9))
      0:       limit = '0;
      1:       limit = 9'($urandom_range(BUF_BYTES + 1, 511));
      2, 3, 4: limit = 9'($urandom_range(1, BUF_BYTES));
      default: limit = MAX_TAKE;
    endcase
    return limit;
  endfunction

  // Present one item; valid stays high after acceptance so back-to-back items need no
  // extra edge. Whoever follows either sends again or lowers valid in this step.
  task automatic drive_rx_item(rx_item_t it);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.now_ms, it.restart, it.read_index, it.max_length, it.error_bits,
                  it.rx_byte};
    in_tuser  <= {it.read_counter, it.echo, it.opcode};
    expected_status.push_back(apply_rx_item(it));
    items_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] value, logic echo);
    rx_item_t it;
    it         = random_item(OP_BYTE);
    it.rx_byte = value;
    it.echo    = echo;
    drive_rx_item(it);
  endtask

  task automatic send_idle(logic [1:0] outcome);
    rx_item_t it;
    it         = random_item(OP_IDLE);
    it.restart = outcome;
    drive_rx_item(it);
  endtask

  task automatic send_error(logic [4:0] bits);
    rx_item_t it;
    it            = random_item(OP_ERROR);
    it.error_bits = bits;
    drive_rx_item(it);
  endtask

  task automatic send_recover(logic [1:0] outcome, logic [31:0] now);
    rx_item_t it;
    it         = random_item(OP_RECOVER);
    it.restart = outcome;
    it.now_ms  = now;
    drive_rx_item(it);
  endtask

  task automatic send_take(logic [8:0] limit);
    rx_item_t it;
    it            = random_item(OP_TAKE);
    it.max_length = limit;
    drive_rx_item(it);
  endtask

  task automatic send_read(logic counter, logic [7:0] index);
    rx_item_t it;
    it              = random_item(OP_READ);
    it.read_counter = counter;
    it.read_index   = index;
    drive_rx_item(it);
  endtask

  // Frame bytes are read only where the ready half has been written.
  task automatic send_read_any();
    logic [8:0] span;
    span = written_span[active_half ^ 1'b1];
    if (span == 0 || $urandom_range(0, 1) == 0)
      send_read(1'b1, 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 6)));
    else
      send_read(1'b0, 8'($urandom_range(0, span - 1)));
  endtask

  task automatic send_random_op();
    logic [4:0] bits;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end else if (pick < 40) begin
      send_idle(pick_outcome());
    end else if (pick < 58) begin
      case ($urandom_range(0, 5))
        0:       bits = '0;
        1:       bits = 5'b1 << ERR_OTHER;
        2, 3:    bits = 5'b1 << $urandom_range(ERR_PARITY, ERR_OVERRUN);
        default: bits = 5'($urandom);
      endcase
      send_error(bits);
    end else if (pick < 72) begin
      if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 9);
      send_recover(pick_outcome(), clock_ms);
    end else if (pick < 84) begin
      send_take(pick_take_limit());
    end else if (pick < 98) begin
      send_read_any();
    end else begin
      drive_rx_item(random_item($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7));
    end
  endtask

  task automatic send_frame_cycle();
    int nbytes;
    nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    repeat (nbytes) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) == 0) send_random_op();
    send_idle(pick_outcome());
    repeat ($urandom_range(0, 2)) send_read_any();
    if ($urandom_range(0, 4) != 0) send_take(pick_take_limit());
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(logic [2:0] index, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      CFG_FE_LIMIT:    lim_fe       = value;
      CFG_PE_LIMIT:    lim_pe       = value;
      CFG_ERR_LIMIT:   lim_err      = value;
      CFG_FAULT_CLEAR: clear_frames = value;
      CFG_MAX_RETRIES: max_retries  = value;
      default: ;
    endcase
  endtask

  task automatic write_limits(logic [7:0] fe, logic [7:0] pe, logic [7:0] err,
                              logic [7:0] clr, logic [7:0] rtr);
    wait_results_drained();
    write_reg(CFG_FE_LIMIT, fe);
    write_reg(CFG_PE_LIMIT, pe);
    write_reg(CFG_ERR_LIMIT, err);
    write_reg(CFG_FAULT_CLEAR, clr);
    write_reg(CFG_MAX_RETRIES, rtr);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_read(1'b1, 8'(CNT_OVERFLOWS));
    send_read(1'b1, SEL_NONE);
    send_read(1'b1, 8'hFF);
    send_idle(RESTART_OK);               // nothing buffered
    send_take(MAX_TAKE);                 // nothing waiting
    drive_rx_item(random_item(OP_RSVD6));
    drive_rx_item(random_item(OP_RSVD7));
    send_recover(RESTART_OK, 32'd100);   // no request pending
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b1);              // echo, dropped
    send_idle(RESTART_BUSY);             // seal, restart requests recovery
    send_byte(8'h5A, 1'b0);
    send_idle(RESTART_OK);               // frame still waiting: overflow
    send_read(1'b0, 8'd0);
    send_read(1'b0, 8'd1);
    send_recover(RESTART_OK, 32'd200);   // blocked by waiting frame
    send_take(9'd0);
    send_take(9'd257);
    send_take(9'h1FF);
    send_take(9'd1);                     // clipped to the limit
    send_recover(RESTART_BUSY, 32'd3);   // too soon after the last attempt
    send_recover(RESTART_BUSY, 32'hFFFF_FFFE);
    send_recover(RESTART_FAIL, 32'd2);   // wrapped gap still too short
    send_recover(RESTART_FAIL, 32'd3);
    send_recover(RESTART_FAIL_ALT, 32'd8);  // retries exhausted, fault latches
    send_error('0);
    send_error(5'b1 << ERR_OTHER);
    send_error(5'h1F);
    send_read(1'b1, SEL_RETRIES);
    clock_ms = 32'd8;
  endtask

  // Fill one half back to back, run past the end, then take with a clipping limit.
  task automatic test_full_buffer();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_take(MAX_TAKE);
    while (fill_count < BUF_BYTES) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);       // past the end: dropped and counted
    send_idle(RESTART_OK);
    send_read(1'b0, 8'hFF);
    send_read(1'b1, 8'(CNT_OVERFLOWS));
    send_take(9'd200);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic(int n);
    int stop_at;
    int iter;
    stop_at = items_sent + n;
    iter    = 0;
    while (items_sent < stop_at) begin
      if (iter % 16 == 0) begin
        in_gaps_on    = $urandom_range(0, 3) != 0;
        out_stalls_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 59) == 0) wait_results_drained();
      if ($urandom_range(0, 9) < 4) send_frame_cycle();
      else send_random_op();
      iter++;
    end
  endtask

  task automatic test_limit_settings();
    write_limits(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    test_random_traffic(70);
    write_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    test_random_traffic(70);
    write_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    test_random_traffic(40);
    repeat (2) begin
      write_limits(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                   8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                   8'($urandom_range(1, 6)));
      test_random_traffic(60);
    end
    write_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)));
    test_random_traffic(60);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    rx_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("frame_waiting", 32'(want.frame_waiting), 32'(out_tdata[0]));
        check_field("taken_length", 32'(want.taken_length), 32'(out_tdata[9:1]));
        check_field("read_data", 32'(want.read_data), 32'(out_tdata[17:10]));
        check_field("counter_value", want.counter_value, out_tdata[49:18]);
        check_field("recovery_pending", 32'(want.recovery_pending), 32'(out_tdata[50]));
        check_field("hardware_fault", 32'(want.hardware_fault), 32'(out_tdata[51]));
        check_field("recovery_tried", 32'(want.recovery_tried), 32'(out_tdata[52]));
      end
    end
  end

  // Result side: draw a stall before each transaction.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(60);
    test_full_buffer();
    test_limit_settings();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("uart_idle_frame_receiver_top_test: done, clean");
    else
      $display("uart_idle_frame_receiver_top_test: done, errors");
    $finish;
  end

endmodule
